@@ design/sliding_median_filter_macros.svh @@
// Assertion macros used by the median filter back end (smf_back).
// The clock is clk and the reset is rst_n in every module that uses them.
`ifndef SLIDING_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SMF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smf assertion failed");
`define SMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smf assertion failed");
`else
`define SMF_ASSERT_SAME(label, ante, cons)
`define SMF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/smf_pkg.sv @@
`default_nettype none

package smf_pkg;

  // Width of one distance sample in millimetres.
  localparam int unsigned DIST_W = 16;

  // Default window length of the filter.
  localparam int unsigned WINDOW_DEF = 5;

  // Number of window snapshots held between the front and the back.
  localparam int unsigned Q_DEPTH = 4;

endpackage

`default_nettype wire

@@ design/smf_if.sv @@
`default_nettype none

// Sample channel into the filter.
interface smf_in_if;
  logic                         valid;
  logic                         ready;
  logic [smf_pkg::DIST_W-1:0]   distance;
  logic                         end_of_scan;

  modport source (output valid, output distance, output end_of_scan, input ready);
  modport sink   (input valid, input distance, input end_of_scan, output ready);
endinterface

// Median channel out of the filter.
interface smf_out_if;
  logic                         valid;
  logic                         ready;
  logic [smf_pkg::DIST_W-1:0]   median;
  logic                         final_of_scan;

  modport source (output valid, output median, output final_of_scan, input ready);
  modport sink   (input valid, input median, input final_of_scan, output ready);
endinterface

`default_nettype wire

@@ design/sliding_median_filter.sv @@
// A median passes the snapshot queue and then the output register on its way out.
// The input takes one item per cycle while the queue is not full; the item that ends a scan
// owes up to WINDOW/2 more medians, which the back end flushes one per cycle unless stalled.
// Reset: synchronous, active low; clears the sample count, queue and output valid.
// The history registers hold no reset value; entries beyond the sample count are never used.
`default_nettype none

// Sliding-window median filter over one lidar scan.
//
// The front end shifts each accepted item into the history and, whenever the
// item owes at least one median, pushes a snapshot of the whole history, the
// sample count and the end-of-scan flag into a short queue. The queue lets the
// input keep flowing while the output is stalled or while a scan is flushed.
//
// The back end takes the head snapshot and produces its medians one per cycle
// while the output is not stalled. An ordinary item owes the median of the
// sample WINDOW/2 positions back. The item that ends a scan also owes the
// medians of every newer position, in sample order, each over its window
// clipped at the scan end. The last of these carries final_of_scan.
//
// The median is found by ranking: every sample in the clipped window is
// compared against every other, ties are broken by position, and the sample
// whose rank equals half the window size is the result. For a window of even
// size this gives the upper median.
module sliding_median_filter #(
  parameter int unsigned WINDOW = smf_pkg::WINDOW_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  smf_in_if.sink    in_ch,
  smf_out_if.source out_ch
);

  localparam int unsigned SEEN_W = $clog2(WINDOW + 1);
  localparam int unsigned DESC_W = WINDOW * smf_pkg::DIST_W + SEEN_W + 1;

  logic              push;
  logic [DESC_W-1:0] push_data;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [DESC_W-1:0] q_data;

  // Front end: history, sample count and snapshot generation.
  smf_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Snapshot queue between the two halves.
  smf_queue #(
    .DATA_W (DESC_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  // Back end: median selection and output register.
  smf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ design/smf_queue.sv @@
`default_nettype none

// Small first-in first-out queue of window snapshots.
module smf_queue #(
  parameter int unsigned DATA_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output logic [DATA_W-1:0]      head_data
);

  localparam int unsigned PTR_W = $clog2(smf_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] mem_r [smf_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNT_W'(smf_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ design/smf_front.sv @@
`default_nettype none

// Accepts samples, keeps the scan history and queues one window snapshot for
// every item that owes at least one median.
module smf_front #(
  parameter int unsigned WINDOW = smf_pkg::WINDOW_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smf_in_if.sink      in_ch,
  output logic        push,
  output logic [WINDOW*smf_pkg::DIST_W + $clog2(WINDOW+1):0] push_data,
  input  wire logic   q_full
);

  localparam int unsigned HALF   = WINDOW / 2;
  localparam int unsigned SEEN_W = $clog2(WINDOW + 1);

  // Entry 0 holds the newest sample.
  logic [WINDOW-1:0][smf_pkg::DIST_W-1:0] hist_r, hist_nxt;
  logic [SEEN_W-1:0]                      seen_r, seen_nxt, seen_inc;
  logic                                   accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    hist_nxt[0] = in_ch.distance;
    for (int j = 1; j < WINDOW; j++) begin
      hist_nxt[j] = hist_r[j-1];
    end
    seen_inc = (seen_r == SEEN_W'(WINDOW)) ? seen_r : seen_r + 1'b1;
    seen_nxt = in_ch.end_of_scan ? '0 : seen_inc;
    push      = accept && (in_ch.end_of_scan || (seen_inc > SEEN_W'(HALF)));
    push_data = {in_ch.end_of_scan, seen_inc, hist_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/smf_back.sv @@
`default_nettype none

`include "sliding_median_filter_macros.svh"

// Expands each queued snapshot into its medians, one per cycle while the output
// is not stalled, and holds the result in the output register.
module smf_back #(
  parameter int unsigned WINDOW = smf_pkg::WINDOW_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire logic [WINDOW*smf_pkg::DIST_W + $clog2(WINDOW+1):0] q_data,
  output logic        q_pop,
  smf_out_if.source   out_ch
);

  localparam int unsigned HALF   = WINDOW / 2;
  localparam int unsigned SEEN_W = $clog2(WINDOW + 1);
  localparam int unsigned C_W    = $clog2(HALF + 1);
  localparam int unsigned SMP_W  = WINDOW * smf_pkg::DIST_W;

  logic [WINDOW-1:0][smf_pkg::DIST_W-1:0] samples;
  logic [SEEN_W-1:0]                      seen;
  logic                                   last;

  logic [C_W-1:0]    c_start, c_eff;
  logic [C_W-1:0]    c_r, c_nxt;
  logic              busy_r, busy_nxt;
  logic              load, emit;
  logic [SEEN_W-1:0] limit, n_valid;
  logic [WINDOW-1:0] in_win;
  logic [SEEN_W-1:0] rank [WINDOW];
  logic [smf_pkg::DIST_W-1:0] med;

  logic                       out_valid_r, out_valid_nxt;
  logic [smf_pkg::DIST_W-1:0] median_r;
  logic                       final_r;

  assign samples = q_data[SMP_W-1:0];
  assign seen    = q_data[SMP_W +: SEEN_W];
  assign last    = q_data[SMP_W + SEEN_W];

  // Center position of the window, counted back from the newest sample.
  always_comb begin
    if (last && (seen <= SEEN_W'(HALF))) begin
      c_start = C_W'(seen - 1'b1);
    end else begin
      c_start = C_W'(HALF);
    end
    c_eff = busy_r ? c_r : c_start;
  end

  // Rank selection: the element whose rank, with ties broken by position,
  // equals half the window size is the median.
  always_comb begin
    limit = SEEN_W'(c_eff) + SEEN_W'(HALF);
    for (int j = 0; j < WINDOW; j++) begin
      in_win[j] = (SEEN_W'(j) < seen) && (SEEN_W'(j) <= limit);
    end
    n_valid = SEEN_W'($countones(in_win));
    med = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (in_win[j] && ((samples[j] < samples[i]) ||
                          ((samples[j] == samples[i]) && (j < i)))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
      if (in_win[i] && (rank[i] == (n_valid >> 1))) begin
        med = med | samples[i];
      end
    end
  end

  always_comb begin
    load          = !out_valid_r || out_ch.ready;
    emit          = load && q_valid;
    q_pop         = emit && (!last || (c_eff == '0));
    busy_nxt      = busy_r;
    c_nxt         = c_r;
    out_valid_nxt = load ? q_valid : out_valid_r;
    if (emit) begin
      busy_nxt = !q_pop;
      c_nxt    = c_eff - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      median_r <= med;
      final_r  <= last && (c_eff == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.median        = median_r;
  assign out_ch.final_of_scan = final_r;

  `SMF_ASSERT_SAME(a_pop_needs_entry, q_pop, q_valid)
  `SMF_ASSERT_SAME(a_busy_only_on_flush, busy_r, q_valid && last)
  `SMF_ASSERT_SAME(a_busy_center_below_half, busy_r, c_r < C_W'(HALF))
  `SMF_ASSERT_NEXT(a_flush_continues, emit && last && (c_eff != '0), busy_r)

endmodule

`default_nettype wire

@@ verif/sliding_median_filter_tb.sv @@
`default_nettype none

// Checks the sliding-window median filter against a behavioral predictor that
// runs beside it. Scans of distance samples go in one item at a time. The
// predictor keeps its own copy of the scan history and works out, for every
// accepted item, the medians that the item owes. Each median item that comes
// out is compared with the oldest of those.
module sliding_median_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN = smf_pkg::WINDOW_DEF;
  localparam int unsigned HALF = WIN / 2;
  localparam int unsigned MAX_REPORTS = 10;
  // Cycles to wait after the last expected median, well beyond the filter's latency.
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef logic [smf_pkg::DIST_W-1:0] dist_t;

  // One expected median item.
  typedef struct packed {
    dist_t median;
    logic  final_of_scan;
  } median_item_t;

  logic clk = 1'b0;
  logic rst_n;

  smf_in_if  in_ch ();
  smf_out_if out_ch ();

  sliding_median_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: the newest samples of the current scan, newest last, and
  // how many samples of the scan have arrived, saturating at the window size.
  dist_t       scan_hist [WIN];
  int unsigned scan_seen;

  median_item_t pending_medians [$];
  int unsigned  error_count;

  // Idle rates of the two sides, in percent, changed from phase to phase.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  // Median of the samples that lie off_lo..off_hi places back from the newest
  // one. Positions outside the scan so far are dropped, which clips the window
  // at both ends of the scan. For an even count the upper median is taken.
  function automatic dist_t clipped_median(input int off_lo, input int off_hi);
    dist_t vals [WIN];
    dist_t v;
    int    n;
    int    j;
    n = 0;
    for (int off = off_lo; off <= off_hi; off++) begin
      if (off < 0 || off >= int'(scan_seen)) continue;
      v = scan_hist[WIN - 1 - off];
      j = n;
      while (j > 0 && vals[j - 1] > v) begin
        vals[j] = vals[j - 1];
        j--;
      end
      vals[j] = v;
      n++;
    end
    return vals[n / 2];
  endfunction

  // Appends one expected median at the tail of the pending list.
  function automatic void queue_expected(input median_item_t m);
    pending_medians = {pending_medians, m};
  endfunction

  // Advances the predicted scan by one accepted item and queues the medians
  // that the item owes: the one for the sample HALF places back, once it
  // exists, and on the last item of a scan those of every newer position.
  function automatic void advance_scan(input dist_t sample_mm, input logic scan_end);
    median_item_t m;
    for (int i = 0; i < WIN - 1; i++) scan_hist[i] = scan_hist[i + 1];
    scan_hist[WIN - 1] = sample_mm;
    if (scan_seen < WIN) scan_seen++;

    if (scan_seen > HALF) begin
      m.median = clipped_median(0, 2 * HALF);
      m.final_of_scan = 1'b0;
      queue_expected(m);
    end

    if (scan_end) begin
      // The flush walks toward the newest sample, whose window is clipped
      // hardest; that last median is the one that closes the scan.
      for (int d = HALF - 1; d >= 0; d--) begin
        if (d >= int'(scan_seen)) continue;
        m.median = clipped_median(d - int'(HALF), d + int'(HALF));
        m.final_of_scan = (d == 0);
        queue_expected(m);
      end
      scan_seen = 0;
    end
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Monitor of both channels. It runs at every rising edge and sees the values
  // from just before the edge, so it agrees with the design on which items
  // were accepted. An input item is predicted before any output item of the
  // same edge is checked.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_ch.valid && in_ch.ready) begin
      advance_scan(in_ch.distance, in_ch.end_of_scan);
    end
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      if (pending_medians.size() == 0) begin
        report_error($sformatf("median item %0d/%0b with nothing expected",
                               out_ch.median, out_ch.final_of_scan));
      end else begin
        if (out_ch.median !== pending_medians[0].median ||
            out_ch.final_of_scan !== pending_medians[0].final_of_scan) begin
          report_error($sformatf("median expected %0d final %0b, got %0d final %0b",
                                 pending_medians[0].median,
                                 pending_medians[0].final_of_scan,
                                 out_ch.median, out_ch.final_of_scan));
        end
        void'(pending_medians.pop_front());
      end
    end
  end

  // The receiver stalls at the rate of the current phase, decided afresh on
  // every cycle so that stalls land on every stage of a flush.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one sample. The sender may first idle for a random number of
  // cycles. Valid stays high after acceptance so that back-to-back items keep
  // the input busy on every cycle.
  task automatic send_sample(input dist_t sample_mm, input logic scan_end);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.distance    <= sample_mm;
    in_ch.end_of_scan <= scan_end;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Sends a whole scan; the last sample carries the end-of-scan flag.
  task automatic send_scan(input dist_t samples [$]);
    foreach (samples[i]) send_sample(samples[i], i == samples.size() - 1);
  endtask

  // Short scans: two single-sample scans at both extremes of the range, then
  // scans of two, three and four samples. The two- and four-sample scans have
  // clipped windows of even size, where the upper median is taken.
  task automatic test_short_scans();
    send_scan('{16'd0});
    send_scan('{16'hFFFF});
    send_scan('{16'd100, 16'd200});
    send_scan('{16'hFFFF, 16'd0, 16'd40});
    send_scan('{16'd7, 16'd7, 16'd3, 16'd7});
  endtask

  // A longer scan with both extremes of the distance range, neighboring
  // values around the top bit, and a run of equal samples before the last two.
  task automatic test_extreme_scan();
    send_scan('{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'h7FFF,
                16'd9, 16'd9, 16'd9, 16'h5555, 16'hAAAA});
  endtask

  // Random scans at the given idle rates until about n_items have gone in.
  // Most scans are short; a few run long. Each scan draws its samples from
  // the full range, a narrow band that forces ties, or mostly the extremes.
  task automatic test_random_scans(input int unsigned n_items,
                                   input int unsigned gap_pct,
                                   input int unsigned stall_pct);
    int unsigned sent;
    int unsigned scan_len;
    int unsigned flavor;
    dist_t       base;
    dist_t       sample_mm;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      scan_len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      flavor   = $urandom_range(2);
      base     = dist_t'($urandom);
      for (int unsigned i = 0; i < scan_len; i++) begin
        case (flavor)
          0: begin
            sample_mm = dist_t'($urandom);
          end
          1: begin
            sample_mm = base + dist_t'($urandom_range(3));
          end
          default: begin
            case ($urandom_range(2))
              0: sample_mm = '0;
              1: sample_mm = '1;
              default: sample_mm = dist_t'($urandom);
            endcase
          end
        endcase
        send_sample(sample_mm, i == scan_len - 1);
      end
      sent += scan_len;
    end
  endtask

  initial begin
    error_count    = 0;
    scan_seen      = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.distance    <= '0;
    in_ch.end_of_scan <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_scans();
    test_extreme_scan();
    test_random_scans(98, 0, 0);
    test_random_scans(98, 45, 0);
    test_random_scans(98, 0, 45);
    test_random_scans(98, 27, 27);

    in_ch.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    // Any median beyond those expected would surface within these cycles.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("sliding_median_filter_tb: done, clean");
    end else begin
      $display("sliding_median_filter_tb: done, errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("sliding_median_filter_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
